// ===== hdl/assert_macros.svh =====
// Assertion macros for the port-level checker file.
// Each macro expands to one labeled concurrent assertion with reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true now implies consequent true now
`define TTS_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// antecedent true now implies consequent true at the next edge
`define TTS_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tts_pkg.sv =====
// Package for the timeout table scanner: item types, codes and constants.
// No dependencies; used by the update unit, the scanner and the checkers.
package tts_pkg;

	localparam int TW = 32;
	localparam int DTW = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_ADD     = 2'd1;
	localparam logic [1:0] OP_ADD_NAK = 2'd2;
	localparam logic [1:0] OP_DEL     = 2'd3;

	localparam logic [1:0] CLS_ACK = 2'd0;
	localparam logic [1:0] CLS_ACT = 2'd1;
	localparam logic [1:0] CLS_NAK = 2'd2;

	localparam logic [1:0] KIND_EVENT   = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ACK_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NAK_PERIOD = 2'd1;

	localparam logic [TW-1:0] ACK_PERIOD_RST = 32'd100;
	localparam logic [TW-1:0] NAK_PERIOD_RST = 32'd50;

	typedef struct packed {
		logic [1:0]     opcode;
		logic [1:0]     op_class;
		logic [TW-1:0]  timer_id;
		logic [TW-1:0]  period;
		logic           one_shot;
		logic [DTW-1:0] elapsed_ticks;
	} cmd_t;

	typedef struct packed {
		logic [1:0]    kind;
		logic [1:0]    event_class;
		logic [TW-1:0] event_id;
		logic [TW-1:0] min_left;
		logic [1:0]    status;
		logic          last;
	} res_t;

	typedef struct packed {
		logic [TW-1:0] id;
		logic [TW-1:0] period;
		logic          oneshot;
		logic [TW-1:0] elapsed;
	} slot_t;

	typedef struct packed {
		logic [TW-1:0] new_elapsed;
		logic          expired;
		logic [TW-1:0] left;
	} unit_res_t;

endpackage

// ===== hdl/tts_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module tts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/tts_unit.sv =====
// Shared timer update unit: saturating elapsed add, expiry compare, time left.
// Depends on tts_pkg.
module tts_unit (
	input  logic [tts_pkg::TW-1:0]  elapsed,
	input  logic [tts_pkg::DTW-1:0] dt,
	input  logic [tts_pkg::TW-1:0]  period,
	output tts_pkg::unit_res_t      res
);

	logic [tts_pkg::TW:0]   sum;
	logic [tts_pkg::TW-1:0] sat;

	assign sum = {1'b0, elapsed} + {{(tts_pkg::TW - tts_pkg::DTW + 1){1'b0}}, dt};
	assign sat = sum[tts_pkg::TW] ? {tts_pkg::TW{1'b1}} : sum[tts_pkg::TW-1:0];

	assign res.new_elapsed = sat;
	assign res.expired     = (sat >= period);
	assign res.left        = period - sat;

endmodule

// ===== hdl/timeout_table_scanner.sv =====
// Timeout table scanner: ack timer plus a table of SLOTS act/nak timers.
// Tick: the ack timer, then two class passes over the table, then a summary; one RAM read per cycle unless held.
// Add: takes the first free slot; delete: scans for a matching class and id; one item at a time.
// Results leave through an output register; a new command is taken once the last is loaded.
// Reset: idle, all slots free, ack elapsed 0, periods 100 and 50; no clearing pass.
module timeout_table_scanner #(
	parameter int SLOTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  tts_pkg::cmd_t                     cmd,
	output logic                              res_valid,
	input  logic                              res_stall,
	output tts_pkg::res_t                     res,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tts_pkg::TW-1:0]            cfg_data
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_ACK, S_SCAN, S_SUM, S_ADD, S_DEL, S_STAT
	} state_t;

	state_t                 state_q;
	tts_pkg::cmd_t          cmd_q;
	logic [tts_pkg::TW-1:0] ack_period_q;
	logic [tts_pkg::TW-1:0] nak_period_q;
	logic [tts_pkg::TW-1:0] ack_elapsed_q;
	logic [SLOTS-1:0]       slot_valid_q;
	logic [SLOTS-1:0]       slot_cls_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   pass_q;
	logic                   issue_q;
	logic                   valid_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   pass_s1;
	logic                   lv_s2;
	logic [tts_pkg::TW-1:0] left_s2;
	logic [tts_pkg::TW-1:0] min_q;
	logic                   have_q;
	logic [1:0]             status_q;
	logic                   res_valid_q;
	tts_pkg::res_t          res_q;

	tts_pkg::slot_t         rdata;
	tts_pkg::slot_t         wdata;
	logic                   we;
	logic [IDX_W-1:0]       waddr;
	logic                   re;
	tts_pkg::unit_res_t     ures;
	logic [tts_pkg::TW-1:0] u_el;
	logic [tts_pkg::TW-1:0] u_per;
	logic                   can_load;
	logic                   proc_s1;
	logic                   hold;
	logic                   match_s1;
	logic                   del_cls;
	logic                   add_cls;
	logic                   load;
	tts_pkg::res_t          res_nxt;

	assign can_load  = !res_valid_q || !res_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign del_cls = (cmd_q.op_class == tts_pkg::CLS_NAK);
	assign add_cls = (cmd_q.opcode == tts_pkg::OP_ADD_NAK) || del_cls;

	assign u_el  = (state_q == S_ACK) ? ack_elapsed_q : rdata.elapsed;
	assign u_per = (state_q == S_ACK) ? ack_period_q : rdata.period;

	tts_unit u_unit (
		.elapsed (u_el),
		.dt      (cmd_q.elapsed_ticks),
		.period  (u_per),
		.res     (ures)
	);

	assign proc_s1  = valid_s1 && slot_valid_q[idx_s1] && (slot_cls_q[idx_s1] == pass_s1);
	assign hold     = (state_q == S_SCAN) && proc_s1 && ures.expired && !can_load;
	assign match_s1 = valid_s1 && slot_valid_q[idx_s1] && (slot_cls_q[idx_s1] == del_cls)
		&& (rdata.id == cmd_q.timer_id);

	assign re = issue_q && (((state_q == S_SCAN) && !hold) || (state_q == S_DEL));

	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wdata = rdata;
		if (state_q == S_SCAN && proc_s1 && !hold) begin
			we            = 1'b1;
			wdata.elapsed = ures.expired ? '0 : ures.new_elapsed;
		end else if (state_q == S_ADD && !slot_valid_q[idx_q]) begin
			we            = 1'b1;
			waddr         = idx_q;
			wdata.id      = cmd_q.timer_id;
			wdata.elapsed = '0;
			if (cmd_q.opcode == tts_pkg::OP_ADD_NAK) begin
				wdata.period  = nak_period_q;
				wdata.oneshot = 1'b1;
			end else begin
				wdata.period  = cmd_q.period;
				wdata.oneshot = cmd_q.one_shot;
			end
		end
	end

	tts_ram #(
		.WIDTH ($bits(tts_pkg::slot_t)),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (idx_q),
		.rdata (rdata)
	);

	always_comb begin
		load    = 1'b0;
		res_nxt = '0;
		case (state_q)
			S_ACK: begin
				load                = ures.expired && can_load;
				res_nxt.kind        = tts_pkg::KIND_EVENT;
				res_nxt.event_class = tts_pkg::CLS_ACK;
			end
			S_SCAN: begin
				load                = proc_s1 && ures.expired && can_load;
				res_nxt.kind        = tts_pkg::KIND_EVENT;
				res_nxt.event_class = pass_s1 ? tts_pkg::CLS_NAK : tts_pkg::CLS_ACT;
				res_nxt.event_id    = rdata.id;
			end
			S_SUM: begin
				load             = can_load;
				res_nxt.kind     = tts_pkg::KIND_SUMMARY;
				res_nxt.min_left = min_q;
				res_nxt.last     = 1'b1;
			end
			S_STAT: begin
				load           = can_load;
				res_nxt.kind   = tts_pkg::KIND_STATUS;
				res_nxt.status = status_q;
				res_nxt.last   = 1'b1;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ADD && !slot_valid_q[idx_q]) begin
			slot_cls_q[idx_q] <= add_cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cmd_q         <= '0;
			ack_period_q  <= tts_pkg::ACK_PERIOD_RST;
			nak_period_q  <= tts_pkg::NAK_PERIOD_RST;
			ack_elapsed_q <= '0;
			slot_valid_q  <= '0;
			idx_q         <= '0;
			pass_q        <= 1'b0;
			issue_q       <= 1'b0;
			valid_s1      <= 1'b0;
			idx_s1        <= '0;
			pass_s1       <= 1'b0;
			lv_s2         <= 1'b0;
			left_s2       <= '0;
			min_q         <= '0;
			have_q        <= 1'b0;
			status_q      <= tts_pkg::ST_OK;
			res_valid_q   <= 1'b0;
			res_q         <= '0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				res_q       <= res_nxt;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tts_pkg::CFG_ACK_PERIOD: ack_period_q <= cfg_data;
					tts_pkg::CFG_NAK_PERIOD: nak_period_q <= cfg_data;
					default: ;
				endcase
			end

			// fold one time left into the running minimum
			if (lv_s2 && (!have_q || left_s2 < min_q)) begin
				min_q  <= left_s2;
				have_q <= 1'b1;
			end
			lv_s2 <= !ures.expired && ((state_q == S_ACK) || ((state_q == S_SCAN) && proc_s1));

			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q    <= cmd;
						idx_q    <= '0;
						pass_q   <= 1'b0;
						valid_s1 <= 1'b0;
						case (cmd.opcode)
							tts_pkg::OP_TICK: begin
								min_q   <= '0;
								have_q  <= 1'b0;
								state_q <= S_ACK;
							end
							tts_pkg::OP_ADD: begin
								if (cmd.op_class inside {tts_pkg::CLS_ACT, tts_pkg::CLS_NAK}) begin
									state_q <= S_ADD;
								end else begin
									status_q <= tts_pkg::ST_OK;
									state_q  <= S_STAT;
								end
							end
							tts_pkg::OP_ADD_NAK: begin
								state_q <= S_ADD;
							end
							default: begin
								if (cmd.op_class inside {tts_pkg::CLS_ACT, tts_pkg::CLS_NAK}) begin
									issue_q <= 1'b1;
									state_q <= S_DEL;
								end else begin
									status_q <= tts_pkg::ST_NOTFOUND;
									state_q  <= S_STAT;
								end
							end
						endcase
					end
				end
				S_ACK: begin
					if (!(ures.expired && !can_load)) begin
						ack_elapsed_q <= ures.expired ? '0 : ures.new_elapsed;
						left_s2       <= ures.left;
						issue_q       <= 1'b1;
						state_q       <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!hold) begin
						left_s2  <= ures.left;
						if (proc_s1 && ures.expired && rdata.oneshot) begin
							slot_valid_q[idx_s1] <= 1'b0;
						end
						valid_s1 <= issue_q;
						idx_s1   <= idx_q;
						pass_s1  <= pass_q;
						if (issue_q) begin
							if (idx_q == LAST_IDX) begin
								idx_q <= '0;
								if (pass_q) begin
									issue_q <= 1'b0;
								end else begin
									pass_q <= 1'b1;
								end
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
						if (!issue_q && !valid_s1 && !lv_s2) begin
							state_q <= S_SUM;
						end
					end
				end
				S_SUM: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				S_ADD: begin
					if (!slot_valid_q[idx_q]) begin
						slot_valid_q[idx_q] <= 1'b1;
						status_q            <= tts_pkg::ST_OK;
						state_q             <= S_STAT;
					end else if (idx_q == LAST_IDX) begin
						status_q <= tts_pkg::ST_FULL;
						state_q  <= S_STAT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DEL: begin
					valid_s1 <= issue_q;
					idx_s1   <= idx_q;
					if (issue_q) begin
						if (idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (match_s1) begin
						slot_valid_q[idx_s1] <= 1'b0;
						status_q             <= tts_pkg::ST_OK;
						state_q              <= S_STAT;
					end else if (valid_s1 && !issue_q) begin
						status_q <= tts_pkg::ST_NOTFOUND;
						state_q  <= S_STAT;
					end
				end
				S_STAT: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/tts_checker.sv =====
// Port-level checker for the timeout table scanner, bound to the top level.
// Depends on tts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tts_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input logic          res_valid,
	input logic          res_stall,
	input tts_pkg::res_t res
);

	`TTS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res), "result item changed while stalled")
	`TTS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall, "block not busy after taking a command item")
	`TTS_ASSERT_NOW(a_done_last, clk, arst_n, $fell(cmd_stall), res_valid && res.last, "block went idle without a final result item pending")
	`TTS_ASSERT_NEXT(a_no_spurious, clk, arst_n, !cmd_stall && !res_valid, !res_valid, "result item appeared with no command in progress")

endmodule

bind timeout_table_scanner tts_checker u_tts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

// ===== tb/sv/timeout_table_scanner_checker.sv =====
`timescale 1ns / 1ps
// Checker for the timeout table scanner: watches the command, result and register
// channels, keeps its own ack timer and timer table, and compares every result item.
// Depends on tts_pkg; reports a failure count and the number of results still due.
module timeout_table_scanner_checker #(
	parameter int SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  logic                          cmd_stall,
	input  tts_pkg::cmd_t                 cmd,
	input  logic                          res_valid,
	input  logic                          res_stall,
	input  tts_pkg::res_t                 res,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [tts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tts_pkg::TW-1:0]        cfg_data,
	output int                            failures,
	output int                            pending
);
	import tts_pkg::*;

	localparam logic [TW-1:0] TMAX = {TW{1'b1}};

	logic [TW-1:0] ack_per;
	logic [TW-1:0] nak_per;
	logic [TW-1:0] ack_el;
	bit            live     [SLOTS];
	logic [1:0]    t_class  [SLOTS];
	logic [TW-1:0] t_id     [SLOTS];
	logic [TW-1:0] t_period [SLOTS];
	logic          t_once   [SLOTS];
	logic [TW-1:0] t_el     [SLOTS];
	res_t          res_due  [$];

	function automatic logic [TW-1:0] sat_sum(input logic [TW-1:0] a,
			input logic [DTW-1:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + {{(TW + 1 - DTW){1'b0}}, b};
		return s[TW] ? TMAX : s[TW-1:0];
	endfunction

	task automatic push_res(input logic [1:0] kind, input logic [1:0] cls,
			input logic [TW-1:0] id, input logic [TW-1:0] remain,
			input logic [1:0] st, input logic last);
		res_t r;
		r.kind = kind;
		r.event_class = cls;
		r.event_id = id;
		r.min_left = remain;
		r.status = st;
		r.last = last;
		res_due.push_back(r);
	endtask

	task automatic run_tick(input logic [DTW-1:0] dt);
		logic [TW-1:0] least;
		logic [TW-1:0] remain;
		logic [1:0]    cls;
		bit            found;
		found = 1'b0;
		least = '0;
		ack_el = sat_sum(ack_el, dt);
		if (ack_el >= ack_per) begin
			ack_el = '0;
			push_res(KIND_EVENT, CLS_ACK, '0, '0, ST_OK, 1'b0);
		end else begin
			least = ack_per - ack_el;
			found = 1'b1;
		end
		for (int c = 0; c < 2; c++) begin
			cls = (c == 0) ? CLS_ACT : CLS_NAK;
			for (int i = 0; i < SLOTS; i++) begin
				if (live[i] && t_class[i] == cls) begin
					t_el[i] = sat_sum(t_el[i], dt);
					if (t_el[i] >= t_period[i]) begin
						t_el[i] = '0;
						push_res(KIND_EVENT, cls, t_id[i], '0, ST_OK, 1'b0);
						if (t_once[i])
							live[i] = 1'b0;
					end else begin
						remain = t_period[i] - t_el[i];
						if (!found || remain < least) begin
							least = remain;
							found = 1'b1;
						end
					end
				end
			end
		end
		push_res(KIND_SUMMARY, '0, '0, least, ST_OK, 1'b1);
	endtask

	task automatic store_timer(input logic [1:0] cls, input logic [TW-1:0] id,
			input logic [TW-1:0] per, input logic once, output logic [1:0] st);
		st = ST_FULL;
		for (int i = 0; i < SLOTS; i++) begin
			if (!live[i] && st == ST_FULL) begin
				live[i] = 1'b1;
				t_class[i] = cls;
				t_id[i] = id;
				t_period[i] = per;
				t_once[i] = once;
				t_el[i] = '0;
				st = ST_OK;
			end
		end
	endtask

	task automatic apply_command(input cmd_t c);
		logic [1:0] st;
		st = ST_OK;
		case (c.opcode)
			OP_TICK: run_tick(c.elapsed_ticks);
			OP_ADD: begin
				if (c.op_class == CLS_ACT || c.op_class == CLS_NAK)
					store_timer(c.op_class, c.timer_id, c.period, c.one_shot, st);
			end
			OP_ADD_NAK: store_timer(CLS_NAK, c.timer_id, nak_per, 1'b1, st);
			OP_DEL: begin
				st = ST_NOTFOUND;
				for (int i = 0; i < SLOTS; i++) begin
					if (st == ST_NOTFOUND && live[i] && t_class[i] == c.op_class &&
							t_id[i] == c.timer_id) begin
						live[i] = 1'b0;
						st = ST_OK;
					end
				end
			end
		endcase
		if (c.opcode != OP_TICK)
			push_res(KIND_STATUS, '0, '0, '0, st, 1'b1);
	endtask

	task automatic report_mismatch(input string what, input logic [TW-1:0] got,
			input logic [TW-1:0] want);
		$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
		failures++;
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		if (res_due.size() == 0) begin
			report_mismatch("result item with nothing due, kind", TW'(got.kind), '0);
		end else begin
			want = res_due.pop_front();
			if (got.kind !== want.kind)
				report_mismatch("kind", TW'(got.kind), TW'(want.kind));
			if (got.event_class !== want.event_class)
				report_mismatch("event_class", TW'(got.event_class), TW'(want.event_class));
			if (got.event_id !== want.event_id)
				report_mismatch("event_id", got.event_id, want.event_id);
			if (got.min_left !== want.min_left)
				report_mismatch("min_left", got.min_left, want.min_left);
			if (got.status !== want.status)
				report_mismatch("status", TW'(got.status), TW'(want.status));
			if (got.last !== want.last)
				report_mismatch("last", TW'(got.last), TW'(want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failures = 0;
			ack_per = ACK_PERIOD_RST;
			nak_per = NAK_PERIOD_RST;
			ack_el = '0;
			foreach (live[i])
				live[i] = 1'b0;
			res_due.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ACK_PERIOD: ack_per = cfg_data;
					CFG_NAK_PERIOD: nak_per = cfg_data;
					default: ;
				endcase
			end
			if (res_valid && !res_stall)
				check_result(res);
			if (cmd_valid && !cmd_stall)
				apply_command(cmd);
			pending <= res_due.size();
		end
	end

endmodule

// ===== tb/sv/timeout_table_scanner_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the timeout table scanner: clock, reset, command stimulus,
// period register writes and result back-pressure; gives the final verdict.
// Depends on tts_pkg, timeout_table_scanner and timeout_table_scanner_checker.
module timeout_table_scanner_tb;
	import tts_pkg::*;

	localparam int SLOTS = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
	localparam logic [1:0] BAD_CLASS = 2'd3;
	localparam logic [TW-1:0] TMAX = {TW{1'b1}};
	localparam logic [DTW-1:0] DTMAX = {DTW{1'b1}};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	cmd_t                 cmd = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TW-1:0]        cfg_data = '0;
	int                   failures;
	int                   pending;
	bit                   calm = 1'b0;
	bit                   hold_req = 1'b0;
	bit                   held = 1'b0;
	int unsigned          cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	timeout_table_scanner #(.SLOTS(SLOTS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	timeout_table_scanner_checker #(.SLOTS(SLOTS)) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.failures  (failures),
		.pending   (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// hold off results for a long stretch once, otherwise stall at random
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				res_stall <= 1'b1;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				res_stall <= 1'b0;
				held <= 1'b1;
			end else begin
				res_stall <= !calm && ($urandom_range(99) < 35);
			end
		end
	end

	function automatic cmd_t cmd_of(input logic [1:0] op, input logic [1:0] cls,
			input logic [TW-1:0] id, input logic [TW-1:0] per, input logic once,
			input logic [DTW-1:0] dt);
		cmd_t c;
		c.opcode = op;
		c.op_class = cls;
		c.timer_id = id;
		c.period = per;
		c.one_shot = once;
		c.elapsed_ticks = dt;
		return c;
	endfunction

	function automatic cmd_t random_command(input logic [1:0] op);
		cmd_t c;
		int r;
		c.opcode = op;
		if ($urandom_range(99) < 85)
			c.op_class = $urandom_range(1) ? CLS_NAK : CLS_ACT;
		else
			c.op_class = $urandom_range(1) ? BAD_CLASS : CLS_ACK;
		r = $urandom_range(99);
		if (r < 70)
			c.timer_id = $urandom_range(5);
		else if (r < 80)
			c.timer_id = TMAX;
		else
			c.timer_id = $urandom;
		r = $urandom_range(99);
		if (r < 15)
			c.period = '0;
		else if (r < 25)
			c.period = $urandom;
		else if (r < 30)
			c.period = TMAX;
		else
			c.period = $urandom_range(300, 1);
		c.one_shot = 1'($urandom_range(1));
		r = $urandom_range(99);
		if (r < 60)
			c.elapsed_ticks = DTW'($urandom_range(120));
		else if (r < 80)
			c.elapsed_ticks = DTW'($urandom);
		else if (r < 90)
			c.elapsed_ticks = DTMAX;
		else
			c.elapsed_ticks = '0;
		return c;
	endfunction

	// keep valid high between back-to-back items; drop it only for a gap
	task automatic send_cmd(input cmd_t c);
		while (!calm && $urandom_range(99) < 35) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	task automatic run_random(input int count);
		int r;
		logic [1:0] op;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99);
			if (r < 35)
				op = OP_TICK;
			else if (r < 65)
				op = OP_ADD;
			else if (r < 80)
				op = OP_ADD_NAK;
			else
				op = OP_DEL;
			send_cmd(random_command(op));
		end
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_periods(input logic [TW-1:0] ack, input logic [TW-1:0] nak);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ACK_PERIOD;
		cfg_data <= ack;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= CFG_NAK_PERIOD;
		cfg_data <= nak;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(cmd_of(OP_TICK, CLS_ACT, '0, '0, 1'b0, '0));
		send_cmd(cmd_of(OP_DEL, CLS_ACT, '0, '0, 1'b0, '0));
		send_cmd(cmd_of(OP_DEL, CLS_ACK, '0, '0, 1'b0, '0));
		send_cmd(cmd_of(OP_DEL, BAD_CLASS, '0, '0, 1'b0, '0));
		send_cmd(cmd_of(OP_ADD, CLS_ACK, 32'd9, 32'd10, 1'b0, '0));
		send_cmd(cmd_of(OP_ADD, BAD_CLASS, 32'd9, 32'd10, 1'b1, '0));
		send_cmd(cmd_of(OP_ADD, CLS_ACT, TMAX, '0, 1'b0, '0));
		send_cmd(cmd_of(OP_ADD, CLS_NAK, '0, TMAX, 1'b1, '0));
		send_cmd(cmd_of(OP_ADD_NAK, CLS_ACT, 32'd7, $urandom, 1'b0, DTMAX));
		send_cmd(cmd_of(OP_ADD, CLS_ACT, TMAX, 32'd3, 1'b1, '0));
		send_cmd(cmd_of(OP_TICK, CLS_NAK, TMAX, TMAX, 1'b1, DTMAX));
		send_cmd(cmd_of(OP_TICK, CLS_ACT, '0, '0, 1'b0, 16'd1));
		send_cmd(cmd_of(OP_DEL, CLS_ACT, TMAX, '0, 1'b0, '0));
		send_cmd(cmd_of(OP_DEL, CLS_ACT, TMAX, '0, 1'b0, '0));
		send_cmd(cmd_of(OP_DEL, CLS_NAK, '0, '0, 1'b0, '0));
		send_cmd(cmd_of(OP_TICK, CLS_ACT, '0, '0, 1'b0, 16'd99));
		drain();

		program_periods('0, TMAX);
		repeat (SLOTS + 2) send_cmd(random_command(OP_ADD_NAK));
		run_random(22);
		drain();

		program_periods(TMAX, 32'd1);
		hold_req <= 1'b1;
		run_random(30);
		drain();

		calm <= 1'b1;
		program_periods($urandom_range(300, 1), $urandom_range(300, 1));
		run_random(25);
		drain();

		calm <= 1'b0;
		program_periods(32'd1, '0);
		run_random(25);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
